[rtl/tkmp_pkg.sv]
// ----------------------------------------------------------------------------
// tkmp_pkg
// Shared types and constants of the top-K merit pool.
// ----------------------------------------------------------------------------
`default_nettype none

package tkmp_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int TAG_W          = 32;
    localparam int MERIT_W        = 32;
    localparam int CAP_W          = 7;

    localparam logic [CAP_W-1:0]   CAP_RESET = 7'd64;
    localparam logic [MERIT_W-1:0] MERIT_ALL_ONES = '1;

    localparam logic OP_OFFER   = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;
    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [MERIT_W-1:0] merit;
    } t_entry;

    typedef struct packed {
        logic               kind;
        logic               accepted;
        logic               threshold_changed;
        logic [MERIT_W-1:0] threshold_merit;
        logic               entry_valid;
        logic [TAG_W-1:0]   entry_tag;
        logic [MERIT_W-1:0] entry_merit;
        logic               last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SORT_WB,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[rtl/tkmp_offer_if.sv]
// ----------------------------------------------------------------------------
// tkmp_offer_if
// Input channel of the merit pool: offer or drain beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkmp_offer_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [tkmp_pkg::TAG_W-1:0]   candidate_tag;
    logic [tkmp_pkg::MERIT_W-1:0] candidate_merit;

    modport source (output valid, output opcode, output candidate_tag,
                    output candidate_merit, input ready);
    modport sink   (input valid, input opcode, input candidate_tag,
                    input candidate_merit, output ready);
endinterface

`default_nettype wire

[rtl/tkmp_result_if.sv]
// ----------------------------------------------------------------------------
// tkmp_result_if
// Result channel of the merit pool: offer responses and drained entries.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkmp_result_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic                        accepted;
    logic                        threshold_changed;
    logic [tkmp_pkg::MERIT_W-1:0] threshold_merit;
    logic                        entry_valid;
    logic [tkmp_pkg::TAG_W-1:0]   entry_tag;
    logic [tkmp_pkg::MERIT_W-1:0] entry_merit;
    logic                        last;

    modport source (output valid, output result_kind, output accepted,
                    output threshold_changed, output threshold_merit,
                    output entry_valid, output entry_tag, output entry_merit,
                    output last, input ready);
    modport sink   (input valid, input result_kind, input accepted,
                    input threshold_changed, input threshold_merit,
                    input entry_valid, input entry_tag, input entry_merit,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/top_k_merit_pool_core.sv]
// ----------------------------------------------------------------------------
// top_k_merit_pool_core
// Keeps the best candidates by merit; slot 0 holds the pool minimum.
// ----------------------------------------------------------------------------
// One beat is taken at a time; ready is low until its results are delivered.
// An appended or replacing offer scans every slot of the pool, one slot read per
// cycle through the single comparator, drains the read pipeline, then makes up
// to two swap writes when the new minimum has to be swapped into slot 0; a
// rejected offer skips the scan. A drain of n >= 2 entries runs an exchange
// sort through the same comparator, then emits the entries one at a time. The
// slot memory has one write and one read port with registered read data, and
// that port pair sets the pace of the scan and the sort.
`default_nettype none

module top_k_merit_pool_core #(
    parameter int POOL_DEPTH = tkmp_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tkmp_pkg::CAP_W-1:0]  i_cfg_wdata,
    tkmp_offer_if.sink                       i_offer,
    tkmp_result_if.source                    o_result
);

    localparam int IdxW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CntW = $clog2(POOL_DEPTH + 1);
    localparam logic [7:0] Depth8 = 8'(POOL_DEPTH);

    tkmp_pkg::t_state  r_state, n_state;
    logic [CntW-1:0]   r_fill, n_fill;
    logic [tkmp_pkg::CAP_W-1:0] r_cap;
    logic              r_pv, n_pv;
    logic              r_sort, n_sort;
    logic [CntW-1:0]   r_j, n_j;
    logic [CntW-1:0]   r_base, n_base;
    logic [IdxW-1:0]   r_pidx, n_pidx;
    logic [IdxW-1:0]   r_cur_idx, n_cur_idx;
    tkmp_pkg::t_entry  r_cand, n_cand;
    tkmp_pkg::t_entry  r_cur, n_cur;
    tkmp_pkg::t_entry  r_s0, n_s0;
    tkmp_pkg::t_entry  r_rd;
    tkmp_pkg::t_result r_res, n_res;

    tkmp_pkg::t_entry  mem [POOL_DEPTH];
    logic              mem_we;
    logic [IdxW-1:0]   mem_wa;
    tkmp_pkg::t_entry  mem_wd;
    logic [IdxW-1:0]   rd_addr;

    logic [7:0]        cap8;
    logic [7:0]        cap_eff;
    logic              pool_full;
    logic              issue;
    logic [CntW:0]     base_next2;
    logic [CntW:0]     j_next;

    assign cap8      = 8'(r_cap);
    assign cap_eff   = (cap8 == 8'd0) ? 8'd1 : ((cap8 > Depth8) ? Depth8 : cap8);
    assign pool_full = 8'(r_fill) >= cap_eff;
    assign issue     = r_j < r_fill;
    assign base_next2 = {1'b0, r_base} + (CntW+1)'(2);
    assign j_next     = {1'b0, r_j} + (CntW+1)'(1);

    assign i_offer.ready = (r_state == tkmp_pkg::ST_IDLE);
    assign o_result.valid             = (r_state == tkmp_pkg::ST_OUT);
    assign o_result.result_kind       = r_res.kind;
    assign o_result.accepted          = r_res.accepted;
    assign o_result.threshold_changed = r_res.threshold_changed;
    assign o_result.threshold_merit   = r_res.threshold_merit;
    assign o_result.entry_valid       = r_res.entry_valid;
    assign o_result.entry_tag         = r_res.entry_tag;
    assign o_result.entry_merit       = r_res.entry_merit;
    assign o_result.last              = r_res.last;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_pv      = 1'b0;
        n_sort    = r_sort;
        n_j       = r_j;
        n_base    = r_base;
        n_pidx    = r_pidx;
        n_cur_idx = r_cur_idx;
        n_cand    = r_cand;
        n_cur     = r_cur;
        n_s0      = r_s0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = r_cur;
        rd_addr   = '0;

        unique case (r_state)
            tkmp_pkg::ST_IDLE: begin
                if (i_offer.valid) begin
                    n_cand.tag   = i_offer.candidate_tag;
                    n_cand.merit = i_offer.candidate_merit;
                    n_j    = '0;
                    n_base = '0;
                    if (i_offer.opcode == tkmp_pkg::OP_OFFER) begin
                        n_state = tkmp_pkg::ST_DECIDE;
                    end else if (r_fill == '0) begin
                        n_res.kind              = tkmp_pkg::KIND_DRAIN;
                        n_res.accepted          = 1'b0;
                        n_res.threshold_changed = 1'b0;
                        n_res.threshold_merit   = tkmp_pkg::MERIT_ALL_ONES;
                        n_res.entry_valid       = 1'b0;
                        n_res.entry_tag         = '0;
                        n_res.entry_merit       = '0;
                        n_res.last              = 1'b1;
                        n_state = tkmp_pkg::ST_OUT;
                    end else if (r_fill == CntW'(1)) begin
                        n_state = tkmp_pkg::ST_EMIT_RD;
                    end else begin
                        n_sort  = 1'b1;
                        n_state = tkmp_pkg::ST_SCAN;
                    end
                end
            end

            tkmp_pkg::ST_DECIDE: begin
                // r_rd holds slot 0 here
                n_sort = 1'b0;
                n_res.kind = tkmp_pkg::KIND_OFFER;
                n_res.last = 1'b1;
                if (!pool_full) begin
                    mem_we = 1'b1;
                    mem_wa = r_fill[IdxW-1:0];
                    mem_wd = r_cand;
                    n_fill = r_fill + CntW'(1);
                    n_res.accepted          = 1'b1;
                    n_res.threshold_changed = 1'b0;
                    n_res.entry_valid       = 1'b0;
                    n_res.entry_tag         = '0;
                    n_res.entry_merit       = '0;
                    n_state = tkmp_pkg::ST_SCAN;
                end else if (r_rd.merit < r_cand.merit) begin
                    mem_we = 1'b1;
                    mem_wa = '0;
                    mem_wd = r_cand;
                    n_res.accepted          = 1'b1;
                    n_res.threshold_changed = 1'b1;
                    n_res.entry_valid       = 1'b1;
                    n_res.entry_tag         = r_rd.tag;
                    n_res.entry_merit       = r_rd.merit;
                    n_state = tkmp_pkg::ST_SCAN;
                end else begin
                    n_res.accepted          = 1'b0;
                    n_res.threshold_changed = 1'b0;
                    n_res.threshold_merit   = r_rd.merit;
                    n_res.entry_valid       = 1'b1;
                    n_res.entry_tag         = r_cand.tag;
                    n_res.entry_merit       = r_cand.merit;
                    n_state = tkmp_pkg::ST_OUT;
                end
            end

            tkmp_pkg::ST_SCAN: begin
                if (issue) begin
                    rd_addr = r_j[IdxW-1:0];
                    n_pidx  = r_j[IdxW-1:0];
                    n_pv    = 1'b1;
                    n_j     = r_j + CntW'(1);
                end
                if (r_pv) begin
                    if (r_pidx == r_base[IdxW-1:0]) begin
                        n_cur     = r_rd;
                        n_cur_idx = r_pidx;
                        if (!r_sort) begin
                            n_s0 = r_rd;
                        end
                    end else if (!r_sort) begin
                        if (r_rd.merit < r_cur.merit) begin
                            n_cur     = r_rd;
                            n_cur_idx = r_pidx;
                        end
                    end else if (r_rd.merit > r_cur.merit) begin
                        mem_we = 1'b1;
                        mem_wa = r_pidx;
                        mem_wd = r_cur;
                        n_cur  = r_rd;
                    end
                end
                if (!issue && !r_pv) begin
                    n_state = r_sort ? tkmp_pkg::ST_SORT_WB : tkmp_pkg::ST_SWAP_A;
                end
            end

            tkmp_pkg::ST_SWAP_A: begin
                n_res.threshold_merit = r_cur.merit;
                if (r_cur_idx != '0) begin
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = r_cur;
                    n_state = tkmp_pkg::ST_SWAP_B;
                end else begin
                    n_state = tkmp_pkg::ST_OUT;
                end
            end

            tkmp_pkg::ST_SWAP_B: begin
                mem_we  = 1'b1;
                mem_wa  = r_cur_idx;
                mem_wd  = r_s0;
                n_state = tkmp_pkg::ST_OUT;
            end

            tkmp_pkg::ST_SORT_WB: begin
                mem_we = 1'b1;
                mem_wa = r_base[IdxW-1:0];
                mem_wd = r_cur;
                if (base_next2 < {1'b0, r_fill}) begin
                    n_base  = r_base + CntW'(1);
                    n_j     = r_base + CntW'(1);
                    n_state = tkmp_pkg::ST_SCAN;
                end else begin
                    n_j     = '0;
                    n_state = tkmp_pkg::ST_EMIT_RD;
                end
            end

            tkmp_pkg::ST_EMIT_RD: begin
                rd_addr = r_j[IdxW-1:0];
                n_state = tkmp_pkg::ST_EMIT_LD;
            end

            tkmp_pkg::ST_EMIT_LD: begin
                n_res.kind              = tkmp_pkg::KIND_DRAIN;
                n_res.accepted          = 1'b0;
                n_res.threshold_changed = 1'b0;
                n_res.threshold_merit   = tkmp_pkg::MERIT_ALL_ONES;
                n_res.entry_valid       = 1'b1;
                n_res.entry_tag         = r_rd.tag;
                n_res.entry_merit       = r_rd.merit;
                n_res.last              = (j_next == {1'b0, r_fill});
                n_state = tkmp_pkg::ST_OUT;
            end

            tkmp_pkg::ST_OUT: begin
                if (o_result.ready) begin
                    if (r_res.kind == tkmp_pkg::KIND_DRAIN && !r_res.last) begin
                        n_j     = r_j + CntW'(1);
                        n_state = tkmp_pkg::ST_EMIT_RD;
                    end else begin
                        if (r_res.kind == tkmp_pkg::KIND_DRAIN) begin
                            n_fill = '0;
                        end
                        n_state = tkmp_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = tkmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkmp_pkg::ST_IDLE;
            r_fill  <= '0;
            r_cap   <= tkmp_pkg::CAP_RESET;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pv    <= n_pv;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sort    <= n_sort;
        r_j       <= n_j;
        r_base    <= n_base;
        r_pidx    <= n_pidx;
        r_cur_idx <= n_cur_idx;
        r_cand    <= n_cand;
        r_cur     <= n_cur;
        r_s0      <= n_s0;
        r_res     <= n_res;
    end

    // slot store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[dv/tkmp_pool_checker.sv]
// ----------------------------------------------------------------------------
// tkmp_pool_checker
// Watches both channels and the capacity port of the merit pool, keeps its
// own copy of the pool, works out the results each accepted beat must give
// and compares every result beat with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tkmp_pool_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tkmp_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic                          i_offer_valid,
    input  logic                          i_offer_ready,
    input  logic                          i_opcode,
    input  logic [tkmp_pkg::TAG_W-1:0]    i_candidate_tag,
    input  logic [tkmp_pkg::MERIT_W-1:0]  i_candidate_merit,
    input  logic                          i_result_valid,
    input  logic                          i_result_ready,
    input  logic                          i_result_kind,
    input  logic                          i_accepted,
    input  logic                          i_threshold_changed,
    input  logic [tkmp_pkg::MERIT_W-1:0]  i_threshold_merit,
    input  logic                          i_entry_valid,
    input  logic [tkmp_pkg::TAG_W-1:0]    i_entry_tag,
    input  logic [tkmp_pkg::MERIT_W-1:0]  i_entry_merit,
    input  logic                          i_last,
    output int                            o_error_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = tkmp_pkg::POOL_DEPTH_DEF;

    logic [tkmp_pkg::TAG_W-1:0]   slot_tag   [DEPTH];
    logic [tkmp_pkg::MERIT_W-1:0] slot_merit [DEPTH];
    int unsigned                  fill;
    logic [tkmp_pkg::CAP_W-1:0]   capacity;
    tkmp_pkg::t_result            pending_results [$];
    int                           errors;

    // 0 acts as 1, anything above the depth as the depth
    function automatic int unsigned live_capacity();
        int unsigned c;
        c = 32'(capacity);
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic logic [tkmp_pkg::MERIT_W-1:0] pool_floor();
        return (fill == 0) ? tkmp_pkg::MERIT_ALL_ONES : slot_merit[0];
    endfunction

    task automatic swap_slots(input int unsigned a, input int unsigned b);
        logic [tkmp_pkg::TAG_W-1:0]   t;
        logic [tkmp_pkg::MERIT_W-1:0] m;
        t = slot_tag[a];
        m = slot_merit[a];
        slot_tag[a]   = slot_tag[b];
        slot_merit[a] = slot_merit[b];
        slot_tag[b]   = t;
        slot_merit[b] = m;
    endtask

    // first lowest entry goes to slot 0
    task automatic raise_minimum();
        int unsigned best;
        best = 0;
        for (int unsigned j = 1; j < fill; j++) begin
            if (slot_merit[j] < slot_merit[best]) best = j;
        end
        if (best != 0) swap_slots(best, 0);
    endtask

    task automatic predict_offer(input logic [tkmp_pkg::TAG_W-1:0] tag,
                                 input logic [tkmp_pkg::MERIT_W-1:0] merit);
        tkmp_pkg::t_result r;
        r      = '0;
        r.kind = tkmp_pkg::KIND_OFFER;
        r.last = 1'b1;
        if (fill < live_capacity()) begin
            slot_tag[fill]   = tag;
            slot_merit[fill] = merit;
            fill++;
            raise_minimum();
            r.accepted = 1'b1;
        end else if (slot_merit[0] < merit) begin
            r.accepted          = 1'b1;
            r.threshold_changed = 1'b1;
            r.entry_valid       = 1'b1;
            r.entry_tag         = slot_tag[0];
            r.entry_merit       = slot_merit[0];
            slot_tag[0]         = tag;
            slot_merit[0]       = merit;
            raise_minimum();
        end else begin
            r.entry_valid = 1'b1;
            r.entry_tag   = tag;
            r.entry_merit = merit;
        end
        r.threshold_merit = pool_floor();
        pending_results.push_back(r);
    endtask

    task automatic predict_drain();
        tkmp_pkg::t_result r;
        r                 = '0;
        r.kind            = tkmp_pkg::KIND_DRAIN;
        r.threshold_merit = tkmp_pkg::MERIT_ALL_ONES;
        if (fill == 0) begin
            r.last = 1'b1;
            pending_results.push_back(r);
        end else begin
            // exchange sort, descending, no swap on equal merit
            for (int unsigned i = 0; i + 1 < fill; i++) begin
                for (int unsigned s = i + 1; s < fill; s++) begin
                    if (slot_merit[s] > slot_merit[i]) swap_slots(s, i);
                end
            end
            for (int unsigned i = 0; i < fill; i++) begin
                r.entry_valid = 1'b1;
                r.entry_tag   = slot_tag[i];
                r.entry_merit = slot_merit[i];
                r.last        = (i + 1 == fill);
                pending_results.push_back(r);
            end
            fill = 0;
        end
    endtask

    task automatic check_field(input string name,
                               input logic [tkmp_pkg::MERIT_W-1:0] want,
                               input logic [tkmp_pkg::MERIT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        tkmp_pkg::t_result want;
        if (!i_rst_n) begin
            fill     = 0;
            capacity = tkmp_pkg::CAP_RESET;
            errors   = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_offer_valid && i_offer_ready) begin
                if (i_opcode == tkmp_pkg::OP_DRAIN) predict_drain();
                else predict_offer(i_candidate_tag, i_candidate_merit);
            end
            if (i_result_valid && i_result_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing outstanding: tag %0h merit %0h",
                           i_entry_tag, i_entry_merit);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_bit("result_kind", want.kind, i_result_kind);
                    check_bit("accepted", want.accepted, i_accepted);
                    check_bit("threshold_changed", want.threshold_changed,
                              i_threshold_changed);
                    check_field("threshold_merit", want.threshold_merit, i_threshold_merit);
                    check_bit("entry_valid", want.entry_valid, i_entry_valid);
                    check_field("entry_tag", want.entry_tag, i_entry_tag);
                    check_field("entry_merit", want.entry_merit, i_entry_merit);
                    check_bit("last", want.last, i_last);
                end
            end
        end
        o_error_count <= errors;
        o_pending     <= pending_results.size();
    end

endmodule

[dv/top_k_merit_pool_core_test.sv]
// ----------------------------------------------------------------------------
// top_k_merit_pool_core_test
// Drives offer and drain beats into the merit pool under a range of
// capacities, with random idling on both sides and one long result
// back-pressure stretch; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module top_k_merit_pool_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 120;

    logic                       i_clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [tkmp_pkg::CAP_W-1:0] cfg_wdata;
    bit                         quiet_tail;
    int                         error_count;
    int                         outstanding;
    int                         idle_run;

    tkmp_offer_if  offer_ch ();
    tkmp_result_if result_ch ();

    always #1 i_clk = ~i_clk;

    top_k_merit_pool_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_offer     (offer_ch),
        .o_result    (result_ch)
    );

    tkmp_pool_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_wdata         (cfg_wdata),
        .i_offer_valid       (offer_ch.valid),
        .i_offer_ready       (offer_ch.ready),
        .i_opcode            (offer_ch.opcode),
        .i_candidate_tag     (offer_ch.candidate_tag),
        .i_candidate_merit   (offer_ch.candidate_merit),
        .i_result_valid      (result_ch.valid),
        .i_result_ready      (result_ch.ready),
        .i_result_kind       (result_ch.result_kind),
        .i_accepted          (result_ch.accepted),
        .i_threshold_changed (result_ch.threshold_changed),
        .i_threshold_merit   (result_ch.threshold_merit),
        .i_entry_valid       (result_ch.entry_valid),
        .i_entry_tag         (result_ch.entry_tag),
        .i_entry_merit       (result_ch.entry_merit),
        .i_last              (result_ch.last),
        .o_error_count       (error_count),
        .o_pending           (outstanding)
    );

    function automatic logic [tkmp_pkg::MERIT_W-1:0] pick_merit();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 15);
            3:       return $urandom_range(0, 1) ? tkmp_pkg::MERIT_ALL_ONES : '0;
            4:       return tkmp_pkg::MERIT_ALL_ONES - $urandom_range(0, 15);
            default: return $urandom_range(0, 255) << 24;
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [tkmp_pkg::TAG_W-1:0] tag,
                             input logic [tkmp_pkg::MERIT_W-1:0] merit);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            offer_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offer_ch.valid           <= 1'b1;
        offer_ch.opcode          <= op;
        offer_ch.candidate_tag   <= tag;
        offer_ch.candidate_merit <= merit;
        @(posedge i_clk);
        while (!offer_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        offer_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [tkmp_pkg::CAP_W-1:0] cap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [tkmp_pkg::CAP_W-1:0] cap, input int items,
                             input int drain_odds, input bit close_with_drain);
        set_capacity(cap);
        repeat (items) begin
            if (drain_odds != 0 && $urandom_range(1, drain_odds) == 1)
                send_item(tkmp_pkg::OP_DRAIN, $urandom(), $urandom());
            else
                send_item(tkmp_pkg::OP_OFFER, $urandom(), pick_merit());
        end
        if (close_with_drain) send_item(tkmp_pkg::OP_DRAIN, $urandom(), $urandom());
    endtask

    initial begin
        quiet_tail               = 1'b0;
        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_wdata                <= '0;
        offer_ch.valid           <= 1'b0;
        offer_ch.opcode          <= tkmp_pkg::OP_OFFER;
        offer_ch.candidate_tag   <= '0;
        offer_ch.candidate_merit <= '0;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // empty drain, extremes at reset capacity
        send_item(tkmp_pkg::OP_DRAIN, '1, '1);
        send_item(tkmp_pkg::OP_OFFER, '0, '0);
        send_item(tkmp_pkg::OP_OFFER, '1, tkmp_pkg::MERIT_ALL_ONES);
        send_item(tkmp_pkg::OP_OFFER, 32'h5a5a_a5a5, 32'h8000_0000);
        send_item(tkmp_pkg::OP_DRAIN, '0, '0);

        // capacity 0 behaves as 1: equal merit rejected, greater replaces
        set_capacity(7'd0);
        send_item(tkmp_pkg::OP_OFFER, 32'h11, 32'd5);
        send_item(tkmp_pkg::OP_OFFER, 32'h12, 32'd5);
        send_item(tkmp_pkg::OP_OFFER, 32'h13, 32'd6);
        send_item(tkmp_pkg::OP_OFFER, 32'h14, 32'd0);
        send_item(tkmp_pkg::OP_OFFER, 32'h15, tkmp_pkg::MERIT_ALL_ONES);
        send_item(tkmp_pkg::OP_DRAIN, '0, '0);

        // ties in scan and sort
        set_capacity(7'd3);
        send_item(tkmp_pkg::OP_OFFER, 32'h21, 32'd7);
        send_item(tkmp_pkg::OP_OFFER, 32'h22, 32'd7);
        send_item(tkmp_pkg::OP_OFFER, 32'h23, 32'd7);
        send_item(tkmp_pkg::OP_OFFER, 32'h24, 32'd7);
        send_item(tkmp_pkg::OP_OFFER, 32'h25, 32'd8);
        send_item(tkmp_pkg::OP_DRAIN, '0, '0);

        // capacity above depth, then lowered under the fill level
        set_capacity(7'd127);
        send_item(tkmp_pkg::OP_OFFER, 32'h31, 32'd10);
        send_item(tkmp_pkg::OP_OFFER, 32'h32, 32'd20);
        send_item(tkmp_pkg::OP_OFFER, 32'h33, 32'd30);
        send_item(tkmp_pkg::OP_OFFER, 32'h34, 32'd40);
        set_capacity(7'd2);
        send_item(tkmp_pkg::OP_OFFER, 32'h35, 32'd5);
        send_item(tkmp_pkg::OP_OFFER, 32'h36, 32'd35);
        send_item(tkmp_pkg::OP_DRAIN, '0, '0);

        run_phase(7'd4,   16, 8,  1'b1);
        run_phase(7'd1,   15, 6,  1'b0);
        run_phase(7'd64,  75, 0,  1'b1);
        run_phase(7'd8,   12, 10, 1'b0);
        run_phase(7'd2,   15, 7,  1'b1);
        run_phase(7'd127, 12, 0,  1'b0);
        run_phase(7'd0,   12, 5,  1'b1);
        run_phase(7'd16,  15, 12, 1'b0);
        wait_idle();
        quiet_tail = 1'b1;
        run_phase(7'd3,   20, 6,  1'b1);

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // result side: random back-pressure bursts and one long hold-off
    initial begin : result_sink
        int beats;
        int burst;
        bit held;
        beats = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) beats++;
            if (!quiet_tail && !held && beats >= HOLD_AFTER) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                result_ch.ready <= 1'b0;
                repeat (burst - 1) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any beat
    initial begin
        idle_run = 0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((offer_ch.valid && offer_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
